FILE: rtl/acdp_pkg.sv
// Package for the anchor chaining scorer: field widths, constants and types.
// No dependencies.
`default_nettype none
package acdp_pkg;
	localparam int POS_W   = 20;
	localparam int W_W     = 8;
	localparam int SCORE_W = 16;
	localparam int SUM_W   = 22;
	localparam int PAR_W   = 9;
	localparam int KMER_W  = 6;
	localparam int RATE_W  = 11;
	localparam int SKIP_W  = 8;
	localparam int SCORE_MAX = 65535;

	localparam logic [1:0] CFG_KMER   = 2'd0;
	localparam logic [1:0] CFG_RATE   = 2'd1;
	localparam logic [1:0] CFG_SKIP   = 2'd2;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [PAR_W-1:0]   parent;
		logic [SUM_W-1:0]   drift;
		logic [SUM_W-1:0]   span;
		logic [SKIP_W:0]    skips;
	} acc_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [SUM_W-1:0]   drift;
		logic [SUM_W-1:0]   span;
	} strand_ent_t;

	typedef struct packed {
		logic [POS_W-1:0] qpos;
		logic [POS_W-1:0] tpos;
		strand_ent_t      same;
		strand_ent_t      opp;
	} hit_ent_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SEED = 6'b000010,
		ST_READ = 6'b000100,
		ST_LINK = 6'b001000,
		ST_EVAL = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/acdp_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter.
`default_nettype none
module acdp_div #(
	parameter int NW = 32,
	parameter int DW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;

	assign shifted = {r_q[DW-1:0], n_q[NW-1]};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				r_q <= diff;
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = n_q;
endmodule
`default_nettype wire

FILE: rtl/anchor_chain_dp_scorer_unit.sv
// Anchor chaining scorer: hit store memory, lookback sequencer, result register.
// Uses acdp_pkg and acdp_div.
// Sequence: a seed divide, then a read and evaluate for each visited predecessor, a weight
// divide when weight > 1 and then a penalty divide for each link tested, then the result
// is loaded. One hit at a time, so lookback depth sets throughput.
// Reset clears control state and the hit count; entries are read only after being written.
`default_nettype none
module anchor_chain_dp_scorer_unit
	import acdp_pkg::*;
#(
	parameter int MAX_HITS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // query_pos, target_pos, weight
	input  wire logic        s_tuser,  // group_start
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // hit_index, score_same, parent_same,
	                                   // score_opposite, parent_opposite
	output logic             m_tuser,  // store_full
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);
	localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int CW = $clog2(MAX_HITS + 1);
	localparam int NUMW = 48;
	localparam int DENW = 33;

	logic [KMER_W-1:0] kmer_q;
	logic [RATE_W-1:0] rate_q;
	logic [SKIP_W-1:0] mskip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_q  <= KMER_W'(31);
			rate_q  <= RATE_W'(51);
			mskip_q <= SKIP_W'(25);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KMER: kmer_q  <= cfg_data[KMER_W-1:0];
				CFG_RATE: rate_q  <= cfg_data;
				CFG_SKIP: mskip_q <= cfg_data[SKIP_W-1:0];
				default: ;
			endcase
		end
	end

	hit_ent_t mem [MAX_HITS];
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	hit_ent_t      mem_wdata, rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	state_t state_q;
	logic [CW-1:0]    count_q, n_q, j_q;
	logic [POS_W-1:0] q_q, t_q;
	logic [W_W-1:0]   w_q;
	acc_t             s_q, o_q;
	logic             same_q;
	logic [5:0]       base_q;
	logic [SUM_W:0]   nd_q, ns_q;
	logic [SCORE_W-1:0] pscore_q, ws_q;
	logic [1:0]       phase_q;
	logic             out_v_q;

	// divider shared by seed, weight and penalty divides
	logic            div_start, div_done;
	logic [NUMW-1:0] div_num, div_quo;
	logic [DENW-1:0] div_den;

	acdp_div #(.NW(NUMW), .DW(DENW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	// predecessor decode
	hit_ent_t          pe;
	strand_ent_t       pse;
	logic [POS_W-1:0]  adt, dq_c, drift_c;
	logic              skip_c, same_c;
	logic [5:0]        base_c;
	always_comb begin
		pe      = rd_q;
		skip_c  = (q_q <= pe.qpos) || (t_q == pe.tpos);
		same_c  = t_q > pe.tpos;
		adt     = same_c ? t_q - pe.tpos : pe.tpos - t_q;
		dq_c    = q_q - pe.qpos;
		drift_c = (adt > dq_c) ? adt - dq_c : dq_c - adt;
		pse     = same_c ? pe.same : pe.opp;
		base_c  = (dq_c < adt) ? ((dq_c > POS_W'(kmer_q)) ? kmer_q : dq_c[5:0])
		                       : ((adt  > POS_W'(kmer_q)) ? kmer_q : adt[5:0]);
	end

	// seed score
	logic [SCORE_W-1:0] seed_c;
	always_comb begin
		if (w_q > 8'd1) seed_c = (div_quo == '0) ? 16'd1 : SCORE_W'(div_quo);
		else if (kmer_q == '0) seed_c = 16'd1;
		else seed_c = SCORE_W'(kmer_q);
	end

	// link evaluation
	acc_t            cur;
	logic            allow;
	logic [SUM_W+RATE_W+1:0] lhs, rhs;
	logic signed [SCORE_W+2:0] cand;
	logic [SCORE_W-1:0] cand_c;
	always_comb begin
		cur   = same_q ? s_q : o_q;
		lhs   = {nd_q, 10'd0};
		rhs   = (SUM_W+RATE_W+2)'(ns_q) * (SUM_W+RATE_W+2)'(rate_q);
		allow = lhs <= rhs;
		cand  = $signed({3'b0, pscore_q}) + $signed({3'b0, ws_q})
		      - $signed((SCORE_W+3)'(div_quo > NUMW'(SCORE_W'('1) + 2)
		                ? NUMW'(SCORE_W'('1)) + 2 : div_quo));
		if (ns_q == '0) cand = $signed({3'b0, pscore_q}) + $signed({3'b0, ws_q});
		if (cand < 1) cand_c = 16'd1;
		else if (cand > SCORE_MAX) cand_c = SCORE_W'(SCORE_MAX);
		else cand_c = cand[SCORE_W-1:0];
	end

	logic stop_c;
	assign stop_c = allow && (cand_c <= cur.score) && ((cur.skips + 1'b1) > {1'b0, mskip_q});

	logic [CW-1:0] pidx;
	assign pidx = j_q - 1'b1;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = DENW'(w_q);
		mem_raddr = pidx[AW-1:0];
		if (state_q == ST_IDLE) begin
			div_num = NUMW'(kmer_q);
			div_den = DENW'(s_tdata[47:40]);
			div_start = s_tvalid && s_tready;
		end else if (state_q == ST_LINK && phase_q == 2'd0) begin
			div_num = NUMW'(base_q);
			div_start = 1'b1;
		end else if (state_q == ST_LINK && phase_q == 2'd2) begin
			div_num = NUMW'(nd_q * ws_q[5:0]);
			div_den = {ns_q, 10'd0};
			div_start = 1'b1;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	logic full_c;
	assign full_c = n_q >= CW'(MAX_HITS);

	// result register is free or being drained this cycle
	logic done_fire;
	assign done_fire = (state_q == ST_DONE) && (!out_v_q || m_tready);

	always_comb begin
		mem_we    = done_fire && !full_c;
		mem_waddr = n_q[AW-1:0];
		mem_wdata.qpos = q_q;
		mem_wdata.tpos = t_q;
		mem_wdata.same = '{s_q.score, s_q.drift, s_q.span};
		mem_wdata.opp  = '{o_q.score, o_q.drift, o_q.span};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			phase_q <= '0;
		end else begin
			if (done_fire) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					q_q <= s_tdata[19:0];
					t_q <= s_tdata[39:20];
					w_q <= s_tdata[47:40];
					n_q <= s_tuser ? '0 : count_q;
					j_q <= s_tuser ? '0 : count_q;
					state_q <= ST_SEED;
				end
				ST_SEED: if (div_done) begin
					s_q <= '{seed_c, '1, '0, SUM_W'(kmer_q), '0};
					o_q <= '{seed_c, '1, '0, SUM_W'(kmer_q), '0};
					state_q <= (j_q == '0) ? ST_DONE : ST_READ;
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (skip_c) begin
						j_q <= pidx;
						state_q <= (pidx == '0) ? ST_DONE : ST_READ;
					end else begin
						same_q   <= same_c;
						base_q   <= base_c;
						nd_q     <= (SUM_W+1)'(pse.drift) + (SUM_W+1)'(drift_c);
						ns_q     <= (SUM_W+1)'(pse.span) + (SUM_W+1)'(dq_c);
						pscore_q <= pse.score;
						phase_q  <= (w_q > 8'd1) ? 2'd0 : 2'd2;
						ws_q     <= SCORE_W'(base_c);
						state_q  <= ST_LINK;
					end
				end
				ST_LINK: begin
					unique case (phase_q)
						2'd0: phase_q <= 2'd1;
						2'd1: if (div_done) begin
							ws_q <= (div_quo == '0 && base_q != '0) ? 16'd1
							                                        : SCORE_W'(div_quo);
							phase_q <= 2'd2;
						end
						2'd2: phase_q <= 2'd3;
						default: if (div_done) begin
							phase_q <= 2'd0;
							j_q <= pidx;
							state_q <= (stop_c || pidx == '0) ? ST_DONE : ST_READ;
							if (allow && cand_c > cur.score) begin
								if (same_q)
									s_q <= '{cand_c, PAR_W'(pidx), nd_q[SUM_W-1:0],
									         ns_q[SUM_W-1:0], '0};
								else
									o_q <= '{cand_c, PAR_W'(pidx), nd_q[SUM_W-1:0],
									         ns_q[SUM_W-1:0], '0};
							end else if (allow) begin
								if (same_q) s_q.skips <= s_q.skips + 1'b1;
								else o_q.skips <= o_q.skips + 1'b1;
							end
						end
					endcase
				end
				ST_DONE: if (done_fire) begin
					if (!full_c) count_q <= n_q + 1'b1;
					m_tdata <= {6'd0, o_q.parent, o_q.score, s_q.parent, s_q.score,
					            full_c ? 8'hFF : n_q[7:0]};
					m_tuser <= full_c;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
endmodule
`default_nettype wire

FILE: bench/acdp_checker.sv
// Checker for anchor_chain_dp_scorer_unit: watches the hit stream, the config
// port and the result stream, predicts each result and compares it word by word.
// Depends on acdp_pkg for widths and config register indexes.
module acdp_checker
	import acdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          words_seen,
	output int          full_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 256;

	typedef struct {
		logic [7:0]         idx;
		logic [SCORE_W-1:0] sc_same;
		logic [PAR_W-1:0]   par_same;
		logic [SCORE_W-1:0] sc_opp;
		logic [PAR_W-1:0]   par_opp;
		logic               full;
	} chain_res_t;

	typedef struct {
		longint unsigned score;
		int              parent;
		longint unsigned drift;
		longint unsigned span;
		int unsigned     skips;
	} chain_acc_t;

	logic [KMER_W-1:0] kmer;
	logic [RATE_W-1:0] rate;
	logic [SKIP_W-1:0] skip_lim;
	int unsigned       n_hits;
	logic [POS_W-1:0]  hq [DEPTH];
	logic [POS_W-1:0]  ht [DEPTH];
	chain_acc_t        ent_same [DEPTH];
	chain_acc_t        ent_opp [DEPTH];
	chain_res_t        expected_chain [$];

	assign pending = expected_chain.size();

	// returns 1 when the lookback has to stop
	function automatic bit extend_chain(inout chain_acc_t a, input chain_acc_t p,
			input longint unsigned dq, input longint unsigned adt,
			input longint unsigned w, input int j);
		longint unsigned nd, ns, base, ws, pen;
		longint          cand;
		nd = p.drift + ((adt > dq) ? adt - dq : dq - adt);
		ns = p.span + dq;
		base = (dq < adt) ? dq : adt;
		if (base > kmer) base = kmer;
		ws = (w > 1) ? base / w : base;
		if (ws == 0 && base > 0) ws = 1;
		pen = (ns > 0) ? (nd * ws) / (ns * 1024) : 0;
		if ((nd << 10) > rate * ns) return 0;
		cand = longint'(p.score) + longint'(ws) - longint'(pen);
		if (cand < 1) cand = 1;
		if (cand > SCORE_MAX) cand = SCORE_MAX;
		if (cand > a.score) begin
			a.score = longint'(unsigned'(cand));
			a.parent = j;
			a.drift = nd & 22'h3FFFFF;
			a.span = ns & 22'h3FFFFF;
			a.skips = 0;
			return 0;
		end
		a.skips++;
		return a.skips > skip_lim;
	endfunction

	task automatic score_hit(input logic gs, input logic [47:0] d);
		longint unsigned q, t, w, seed;
		chain_acc_t      s, o;
		chain_res_t      r;
		int unsigned     n;
		bit              stop;
		q = d[19:0];
		t = d[39:20];
		w = d[47:40];
		if (gs) n_hits = 0;
		n = n_hits;
		seed = (w > 1) ? kmer / w : kmer;
		if (seed == 0) seed = 1;
		s = '{seed, -1, 0, kmer, 0};
		o = s;
		for (int j = int'(n) - 1; j >= 0; j--) begin
			if (q <= hq[j] || t == ht[j]) continue;
			if (t > ht[j])
				stop = extend_chain(s, ent_same[j], q - hq[j], t - ht[j], w, j);
			else
				stop = extend_chain(o, ent_opp[j], q - hq[j], ht[j] - t, w, j);
			if (stop) break;
		end
		r.full = (n >= DEPTH);
		if (!r.full) begin
			hq[n] = POS_W'(q);
			ht[n] = POS_W'(t);
			ent_same[n] = s;
			ent_opp[n] = o;
			n_hits = n + 1;
		end
		r.idx = r.full ? 8'd255 : n[7:0];
		r.sc_same = s.score[15:0];
		r.par_same = s.parent[8:0];
		r.sc_opp = o.score[15:0];
		r.par_opp = o.parent[8:0];
		expected_chain.insert(expected_chain.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		chain_res_t e;
		if (!arst_n) begin
			kmer = KMER_W'(31);
			rate = RATE_W'(51);
			skip_lim = SKIP_W'(25);
			n_hits = 0;
			errors = 0;
			words_seen = 0;
			full_seen = 0;
			expected_chain.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KMER: kmer = cfg_data[KMER_W-1:0];
					CFG_RATE: rate = cfg_data;
					CFG_SKIP: skip_lim = cfg_data[SKIP_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				words_seen++;
				if (expected_chain.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none, actual %h/%b",
						$time, m_tdata, m_tuser);
				end else begin
					e = expected_chain.pop_front();
					if (m_tuser) full_seen++;
					if (m_tdata !== {6'b0, e.par_opp, e.sc_opp, e.par_same, e.sc_same, e.idx}
							|| m_tuser !== e.full) begin
						errors++;
						$display("%0t: mismatch expected idx=%0d ss=%0d ps=%0d so=%0d po=%0d full=%0b",
							$time, e.idx, e.sc_same, $signed(e.par_same), e.sc_opp,
							$signed(e.par_opp), e.full);
						$display("%0t:          actual   idx=%0d ss=%0d ps=%0d so=%0d po=%0d full=%0b",
							$time, m_tdata[7:0], m_tdata[23:8], $signed(m_tdata[32:24]),
							m_tdata[48:33], $signed(m_tdata[57:49]), m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) score_hit(s_tuser, s_tdata);
		end
	end
endmodule

FILE: bench/testbench.sv
// Top of the bench for anchor_chain_dp_scorer_unit: clock, reset, hit groups,
// config phases and random back-pressure; verdict from acdp_checker.
// Depends on acdp_pkg, anchor_chain_dp_scorer_unit and acdp_checker.
module testbench
	import acdp_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 12_000_000;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [47:0] s_tdata;
	logic        m_tvalid, m_tready, m_tuser;
	logic [63:0] m_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;
	int          errors, pending, words_seen, full_seen;
	int          hits_sent;
	bit          rx_steady;
	longint      cycles;

	anchor_chain_dp_scorer_unit dut (.*);

	acdp_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receiver stalls: runs of ready and gaps, with stall-free stretches
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			m_tready <= 1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			if (!rx_steady) begin
				m_tready <= 0;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(20, 150)) @(negedge clk);
				else
					repeat ($urandom_range(0, 3)) @(negedge clk);
			end
		end
	end

	task automatic send_hit(input logic gs, input logic [19:0] q, input logic [19:0] t,
			input logic [7:0] w);
		s_tvalid <= 1;
		s_tuser <= gs;
		s_tdata <= {w, t, q};
		do @(posedge clk); while (!s_tready);
		hits_sent++;
		@(negedge clk);
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			s_tdata <= 48'({$urandom, $urandom});
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(20, 120)) @(negedge clk);
			else
				repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_regs(input logic [10:0] k, input logic [10:0] r, input logic [10:0] sk);
		settle();
		write_reg(CFG_KMER, k);
		write_reg(CFG_RATE, r);
		write_reg(CFG_SKIP, sk);
	endtask

	function automatic logic [7:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(0, 255));
			1: return 8'd255;
			default: return 8'($urandom_range(1, 4));
		endcase
	endfunction

	// style: 0 same strand, 1 opposite strand, 2 mixed, 3 noise
	task automatic send_group(input int len, input int style);
		logic [19:0] q, t;
		int          step;
		q = 20'($urandom);
		t = 20'($urandom);
		for (int i = 0; i < len; i++) begin
			if (i > 0) begin
				step = $urandom_range(0, 40);
				q = q + 20'(step);
				case (style)
					0: t = 20'(t + step + $urandom_range(0, 4) - 2);
					1: t = 20'(t - step + $urandom_range(0, 4) - 2);
					2: t = 20'(t + $urandom_range(0, 80) - 40);
					default: begin
						q = 20'($urandom);
						t = 20'($urandom);
					end
				endcase
			end
			send_hit(i == 0, q, t, pick_weight());
		end
	endtask

	initial begin
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		hits_sent = 0;
		rx_steady = 0;
		arst_n = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: field extremes, equal query, equal target, out of order
		send_hit(1, 20'd0, 20'd0, 8'd1);
		send_hit(0, 20'd100, 20'd100, 8'd0);
		send_hit(0, 20'd100, 20'd200, 8'd1);
		send_hit(0, 20'd130, 20'd100, 8'd2);
		send_hit(0, 20'd160, 20'd70, 8'd255);
		send_hit(0, 20'd50, 20'd50, 8'd3);
		send_hit(0, 20'hFFFFF, 20'hFFFFF, 8'd1);
		send_hit(1, 20'hFFFFF, 20'd0, 8'd128);
		send_hit(1, 20'd10, 20'hFFFFF, 8'd1);
		send_hit(0, 20'd20, 20'hFFFF5, 8'd1);
		send_hit(0, 20'd30, 20'hFFFEB, 8'd1);
		send_hit(0, 20'd40, 20'hFFFF0, 8'd1);
		set_regs(11'd1, 11'd0, 11'd0);
		write_reg(CFG_UNUSED, 11'h7FF);
		send_group(8, 0);
		send_group(6, 1);
		set_regs(11'd63, 11'h7FF, 11'd255);
		send_group(10, 2);

		// store overflow: drift-free diagonal keeps the lookback short
		set_regs(11'd31, 11'd1024, 11'd0);
		for (int i = 0; i < 300; i++)
			send_hit(i == 0, 20'(1000 + 5 * i), 20'(2000 + 5 * i), 8'd1);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_regs(11'd31, 11'd51, 11'd25);
				1: set_regs(11'd63, 11'd1024, 11'd255);
				2: set_regs(11'd1, 11'd0, 11'd0);
				default: set_regs(11'($urandom_range(1, 63)), 11'($urandom_range(0, 1024)),
					11'($urandom_range(0, 40)));
			endcase
			rx_steady = (ph == 4);
			for (int n = 0; n < 170; ) begin
				int len;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 32) :
					$urandom_range(1, 10);
				send_group(len, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : 3);
				n += len;
				if (ph == 5 && n > 80 && n < 100) settle();
			end
		end
		rx_steady = 0;

		settle();
		repeat (400) @(negedge clk);
		$display("covered %0d hits, %0d result words, %0d store-full results, %0d cycles",
			hits_sent, words_seen, full_seen, cycles);
		$display("config phases: defaults, both extremes, random; store overflow group");
		if (errors == 0 && pending == 0 && words_seen == hits_sent)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
